// ===== design/sxfb_pkg.sv =====
package sxfb_pkg;

  localparam int SCREEN_WIDTH_DEF  = 64;
  localparam int SCREEN_HEIGHT_DEF = 32;

  localparam int ROW_STORE   = 32;
  localparam int ROW_AW      = 5;
  localparam int ROW_W       = 64;
  localparam int COL_W       = 6;
  localparam int SPRITE_BITS = 8;
  localparam int COORD_W     = 8;
  localparam int CNT_W       = 4;

  localparam logic FUNC_CLEAR = 1'b0;
  localparam logic FUNC_DRAW  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_CLR
  } sxfb_state_t;

  typedef struct packed {
    logic              rd_en;
    logic [ROW_AW-1:0] rd_addr;
    logic              wr_en;
    logic [ROW_AW-1:0] wr_addr;
    logic              clr_all;
  } sxfb_mem_req_t;

endpackage

// ===== design/sxfb_row_mem.sv =====
module sxfb_row_mem
  import sxfb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  sxfb_mem_req_t        req,
  input  logic [ROW_W-1:0]     wr_data,
  output logic [ROW_W-1:0]     rd_data
);

  logic [ROW_W-1:0]     mem [ROW_STORE];
  logic [ROW_STORE-1:0] vld_r;
  logic [ROW_W-1:0]     rd_data_r;
  logic                 rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  // unwritten rows read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.clr_all) begin
        vld_r <= '0;
      end else if (req.wr_en) begin
        vld_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= vld_r[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

// ===== design/sprite_xor_framebuffer_unit.sv =====
// Monochrome framebuffer with sprite XOR drawing. A transaction is taken when start is high and
// busy is low. A draw transaction keeps busy high while the row read from the row memory is
// modified and written back (state ST_MOD); its result is strobed on out_valid in the following
// cycle, and no new transaction is taken until that row is written back. A clear transaction
// keeps busy high while it steps through the rows (SCREEN_HEIGHT, held to 1..32) and
// strobes one zeroed row per cycle, top to bottom, with out_last on the final row; the stored
// rows are invalidated at once, so there is no clearing pass after reset or clear. Results
// cannot be held off: each is on the out_ ports for exactly one cycle and must be taken then.
module sprite_xor_framebuffer_unit
  import sxfb_pkg::*;
#(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
)(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_func,
  input  logic [COORD_W-1:0] in_sprite_byte,
  input  logic [COORD_W-1:0] in_x_pos,
  input  logic [COORD_W-1:0] in_y_pos,
  input  logic               in_last_row,
  output logic               out_valid,
  output logic [ROW_AW-1:0]  out_row_index,
  output logic [ROW_W-1:0]   out_row_bits,
  output logic               out_collision,
  output logic               out_last
);

  localparam int USE_H = (SCREEN_HEIGHT < 1) ? 1 :
                         ((SCREEN_HEIGHT > ROW_STORE) ? ROW_STORE : SCREEN_HEIGHT);
  localparam int USE_W = (SCREEN_WIDTH < SPRITE_BITS) ? SPRITE_BITS :
                         ((SCREEN_WIDTH > ROW_W) ? ROW_W : SCREEN_WIDTH);
  localparam int NCOORD = 1 << COORD_W;
  localparam int NCNT   = 1 << CNT_W;

  sxfb_state_t state_r, state_nxt;

  logic [ROW_AW-1:0]      addr_r, addr_nxt;
  logic [SPRITE_BITS-1:0] pat_r, pat_nxt;
  logic [COL_W-1:0]       xmod_r, xmod_nxt;
  logic                   last_r, last_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   coll_r, coll_nxt;
  logic [ROW_AW-1:0]      clr_idx_r, clr_idx_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [ROW_AW-1:0]      out_row_r, out_row_nxt;
  logic [ROW_W-1:0]       out_bits_r, out_bits_nxt;
  logic                   out_coll_r, out_coll_nxt;
  logic                   out_last_r, out_last_nxt;

  logic [ROW_AW-1:0]      y_mod_tab   [NCOORD];
  logic [COL_W-1:0]       x_mod_tab   [NCOORD];
  logic [ROW_AW-1:0]      cnt_mod_tab [NCNT];

  logic                   accept;
  logic                   clr_done;
  logic [ROW_AW:0]        row_sum;
  logic [ROW_AW-1:0]      row_calc;
  logic [ROW_W-1:0]       mask;
  logic [ROW_W-1:0]       old_bits;
  logic [ROW_W-1:0]       new_bits;
  logic                   hit;
  sxfb_mem_req_t          mem_req;

  for (genvar i = 0; i < NCOORD; i++) begin : g_coord_tab
    assign y_mod_tab[i] = ROW_AW'(i % USE_H);
    assign x_mod_tab[i] = COL_W'(i % USE_W);
  end

  for (genvar i = 0; i < NCNT; i++) begin : g_cnt_tab
    assign cnt_mod_tab[i] = ROW_AW'(i % USE_H);
  end

  assign accept = start & ~busy;

  // both terms are below USE_H, so one subtract wraps the sum
  always_comb begin
    row_sum = {1'b0, y_mod_tab[in_y_pos]} + {1'b0, cnt_mod_tab[cnt_r]};
    if (row_sum >= (ROW_AW+1)'(USE_H)) begin
      row_calc = ROW_AW'(row_sum - (ROW_AW+1)'(USE_H));
    end else begin
      row_calc = row_sum[ROW_AW-1:0];
    end
  end

  always_comb begin
    logic [COL_W:0] col;
    mask = '0;
    for (int j = 0; j < SPRITE_BITS; j++) begin
      col = {1'b0, xmod_r} + (COL_W+1)'(j);
      if (col >= (COL_W+1)'(USE_W)) begin
        col = col - (COL_W+1)'(USE_W);
      end
      if (pat_r[SPRITE_BITS-1-j]) begin
        mask[col[COL_W-1:0]] = 1'b1;
      end
    end
  end

  assign hit      = |(old_bits & mask);
  assign new_bits = old_bits ^ mask;
  assign clr_done = (clr_idx_r == ROW_AW'(USE_H - 1));

  sxfb_row_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .wr_data (new_bits),
    .rd_data (old_bits)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_func == FUNC_DRAW) ? ST_MOD : ST_CLR;
        end
      end
      ST_MOD: begin
        state_nxt = ST_IDLE;
      end
      ST_CLR: begin
        if (clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy            = 1'b1;
    mem_req         = '0;
    mem_req.rd_addr = row_calc;
    mem_req.wr_addr = addr_r;
    unique case (state_r)
      ST_IDLE: begin
        busy            = 1'b0;
        mem_req.rd_en   = start & (in_func == FUNC_DRAW);
        mem_req.clr_all = start & (in_func == FUNC_CLEAR);
      end
      ST_MOD: begin
        mem_req.wr_en = 1'b1;
      end
      ST_CLR: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    addr_nxt      = addr_r;
    pat_nxt       = pat_r;
    xmod_nxt      = xmod_r;
    last_nxt      = last_r;
    cnt_nxt       = cnt_r;
    coll_nxt      = coll_r;
    clr_idx_nxt   = clr_idx_r;
    out_valid_nxt = 1'b0;
    out_row_nxt   = out_row_r;
    out_bits_nxt  = out_bits_r;
    out_coll_nxt  = out_coll_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_func == FUNC_DRAW) begin
            addr_nxt = row_calc;
            pat_nxt  = in_sprite_byte;
            xmod_nxt = x_mod_tab[in_x_pos];
            last_nxt = in_last_row;
          end else begin
            cnt_nxt     = '0;
            coll_nxt    = 1'b0;
            clr_idx_nxt = '0;
          end
        end
      end
      ST_MOD: begin
        out_valid_nxt = 1'b1;
        out_row_nxt   = addr_r;
        out_bits_nxt  = new_bits;
        out_coll_nxt  = last_r & (coll_r | hit);
        out_last_nxt  = last_r;
        if (last_r) begin
          cnt_nxt  = '0;
          coll_nxt = 1'b0;
        end else begin
          cnt_nxt  = cnt_r + CNT_W'(1);
          coll_nxt = coll_r | hit;
        end
      end
      ST_CLR: begin
        out_valid_nxt = 1'b1;
        out_row_nxt   = clr_idx_r;
        out_bits_nxt  = '0;
        out_coll_nxt  = 1'b0;
        out_last_nxt  = clr_done;
        clr_idx_nxt   = clr_idx_r + ROW_AW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      coll_r      <= 1'b0;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      coll_r      <= coll_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    pat_r      <= pat_nxt;
    xmod_r     <= xmod_nxt;
    last_r     <= last_nxt;
    out_row_r  <= out_row_nxt;
    out_bits_r <= out_bits_nxt;
    out_coll_r <= out_coll_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_row_index = out_row_r;
  assign out_row_bits  = out_bits_r;
  assign out_collision = out_coll_r;
  assign out_last      = out_last_r;

endmodule

// ===== design/sxfb_checker.sv =====
module sxfb_checker
  import sxfb_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               in_func,
  input logic               out_valid,
  input logic [ROW_AW-1:0]  out_row_index,
  input logic [ROW_W-1:0]   out_row_bits,
  input logic               out_collision,
  input logic               out_last
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted transaction");

  a_draw_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func == FUNC_DRAW) |=> ##1 out_valid)
    else $error("draw result not strobed two cycles after acceptance");

  a_clear_first: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func == FUNC_CLEAR) |=> ##1
      (out_valid && out_row_index == '0 && out_row_bits == '0))
    else $error("clear did not start with zeroed row 0");

  a_coll_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> !out_collision)
    else $error("collision set on a non-final result");

endmodule

bind sprite_xor_framebuffer_unit sxfb_checker u_sxfb_checker (.*);

// ===== sim/sprite_xor_framebuffer_unit_tb.sv =====
`timescale 1ns / 1ps

module sprite_xor_framebuffer_unit_tb
  import sxfb_pkg::*;
();

  localparam int SCR_W = SCREEN_WIDTH_DEF;
  localparam int SCR_H = SCREEN_HEIGHT_DEF;
  localparam int USE_W = (SCR_W < 8) ? 8 : ((SCR_W > 64) ? 64 : SCR_W);
  localparam int USE_H = (SCR_H < 1) ? 1 : ((SCR_H > ROW_STORE) ? ROW_STORE : SCR_H);

  localparam int RANDOM_CMDS  = 385;
  localparam int DRAIN_CYCLES = 2 * USE_H + 20;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    logic [ROW_AW-1:0] row_index;
    logic [ROW_W-1:0]  row_bits;
    logic              collision;
    logic              last;
  } row_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_func = FUNC_CLEAR;
  logic [COORD_W-1:0] in_sprite_byte = '0;
  logic [COORD_W-1:0] in_x_pos = '0;
  logic [COORD_W-1:0] in_y_pos = '0;
  logic               in_last_row = 1'b0;
  logic               out_valid;
  logic [ROW_AW-1:0]  out_row_index;
  logic [ROW_W-1:0]   out_row_bits;
  logic               out_collision;
  logic               out_last;

  row_result_t        expected_rows[$];
  logic [ROW_W-1:0]   fb_model[ROW_STORE];
  logic [CNT_W-1:0]   sprite_rows_done;
  logic               sprite_hit;
  int                 mismatch_count = 0;
  int                 cmds_sent = 0;
  bit                 gaps_on = 1'b1;

  sprite_xor_framebuffer_unit #(
    .SCREEN_WIDTH (SCR_W),
    .SCREEN_HEIGHT(SCR_H)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_func       (in_func),
    .in_sprite_byte(in_sprite_byte),
    .in_x_pos      (in_x_pos),
    .in_y_pos      (in_y_pos),
    .in_last_row   (in_last_row),
    .out_valid     (out_valid),
    .out_row_index (out_row_index),
    .out_row_bits  (out_row_bits),
    .out_collision (out_collision),
    .out_last      (out_last)
  );

  always #2 clk = ~clk;

  function automatic void predict_display_cmd(input logic func, input logic [7:0] pattern,
                                              input logic [7:0] xs, input logic [7:0] ys,
                                              input logic is_last);
    row_result_t      res;
    int               row;
    logic [ROW_W-1:0] mask;
    if (func == FUNC_CLEAR) begin
      for (int i = 0; i < USE_H; i++) begin
        fb_model[i]   = '0;
        res.row_index = ROW_AW'(i);
        res.row_bits  = '0;
        res.collision = 1'b0;
        res.last      = (i == USE_H - 1);
        expected_rows.insert(expected_rows.size(), res);
      end
      sprite_rows_done = '0;
      sprite_hit       = 1'b0;
      return;
    end
    row  = (int'(ys) + int'(sprite_rows_done)) % USE_H;
    mask = '0;
    for (int j = 0; j < SPRITE_BITS; j++) begin
      if (pattern[SPRITE_BITS-1-j]) mask[(int'(xs) + j) % USE_W] = 1'b1;
    end
    if ((fb_model[row] & mask) != '0) sprite_hit = 1'b1;
    fb_model[row] = fb_model[row] ^ mask;
    res.row_index = ROW_AW'(row);
    res.row_bits  = fb_model[row];
    res.collision = is_last ? sprite_hit : 1'b0;
    res.last      = is_last;
    expected_rows.insert(expected_rows.size(), res);
    if (is_last) begin
      sprite_rows_done = '0;
      sprite_hit       = 1'b0;
    end else begin
      sprite_rows_done = sprite_rows_done + 1'b1;
    end
  endfunction

  // start stays high across back-to-back transactions; it drops only for an idle gap
  task automatic issue_cmd(input logic func, input logic [7:0] pattern, input logic [7:0] xs,
                           input logic [7:0] ys, input logic is_last);
    int gap;
    int pick;
    pick = $urandom_range(0, 99);
    if (!gaps_on || pick < 50) gap = 0;
    else if (pick < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(4, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_func        <= func;
    in_sprite_byte <= pattern;
    in_x_pos       <= xs;
    in_y_pos       <= ys;
    in_last_row    <= is_last;
    do @(posedge clk); while (busy !== 1'b0);
    predict_display_cmd(func, pattern, xs, ys, is_last);
    cmds_sent++;
  endtask

  always @(posedge clk) begin
    row_result_t want;
    if (rst_n && out_valid !== 1'b0) begin
      if (expected_rows.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected row result: idx %0d bits %h coll %b last %b (valid %b)",
                   out_row_index, out_row_bits, out_collision, out_last, out_valid);
      end else begin
        want = expected_rows.pop_front();
        if (out_valid !== 1'b1 || out_row_index !== want.row_index ||
            out_row_bits !== want.row_bits || out_collision !== want.collision ||
            out_last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("row mismatch: exp %0d %h %b %b / got %0d %h %b %b",
                     want.row_index, want.row_bits, want.collision, want.last,
                     out_row_index, out_row_bits, out_collision, out_last);
        end
      end
    end
  end

  task automatic test_directed();
    issue_cmd(FUNC_CLEAR, 8'h00, 8'h00, 8'h00, 1'b1);
    issue_cmd(FUNC_DRAW, 8'hFF, 8'h00, 8'h00, 1'b1);
    // same sprite again erases it: collision
    issue_cmd(FUNC_DRAW, 8'hFF, 8'h00, 8'h00, 1'b1);
    issue_cmd(FUNC_DRAW, 8'h01, 8'hFF, 8'hFF, 1'b1);
    issue_cmd(FUNC_DRAW, 8'h80, 8'h3F, 8'h1F, 1'b1);
    // seventeen-row sprite: row count wraps back to the start row
    for (int i = 0; i < 17; i++) begin
      case (i)
        0:       issue_cmd(FUNC_DRAW, 8'hFF, 8'h3C, 8'h00, 1'b0);
        1:       issue_cmd(FUNC_DRAW, 8'h00, 8'h3C, 8'h00, 1'b0);
        16:      issue_cmd(FUNC_DRAW, 8'h81, 8'h3C, 8'h00, 1'b1);
        default: issue_cmd(FUNC_DRAW, 8'(8'h11 * i), 8'h3C, 8'h00, 1'b0);
      endcase
    end
    // clear abandons a sprite in progress
    issue_cmd(FUNC_DRAW, 8'hA5, 8'h10, 8'h05, 1'b0);
    issue_cmd(FUNC_CLEAR, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    issue_cmd(FUNC_DRAW, 8'h5A, 8'h10, 8'h05, 1'b1);
  endtask

  task automatic test_random();
    int kind;
    int len;
    logic [7:0] xs;
    logic [7:0] ys;
    while (cmds_sent < RANDOM_CMDS + 25) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      kind    = $urandom_range(0, 99);
      xs      = 8'($urandom_range(0, 255));
      ys      = 8'($urandom_range(0, 255));
      if (kind < 4) begin
        issue_cmd(FUNC_CLEAR, 8'($urandom_range(0, 255)), xs, ys, 1'($urandom_range(0, 1)));
      end else if (kind < 14) begin
        issue_cmd(FUNC_DRAW, 8'($urandom_range(0, 255)), xs, ys, 1'($urandom_range(0, 1)));
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 18) : $urandom_range(1, 15);
        for (int i = 0; i < len; i++)
          issue_cmd(FUNC_DRAW, 8'($urandom_range(0, 255)), xs, ys, i == len - 1);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < ROW_STORE; i++) fb_model[i] = '0;
    sprite_rows_done = '0;
    sprite_hit       = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random();
    start <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_rows.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
